FILE: sv/pid_dr_pkg.sv
`timescale 1ns / 1ps

package pid_dr_pkg;

  // Field widths
  localparam int MV_W    = 16;
  localparam int GAIN_W  = 32;
  localparam int DUTY_W  = 13;
  localparam int ISUM_W  = 32;
  localparam int ERR_W   = MV_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W  = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 3'd5;

  // Reset values
  localparam logic [DUTY_W-1:0] DUTY_RESET     = 13'd1500;
  localparam logic [DUTY_W-1:0] THRESH_RESET   = 13'd7150;
  localparam logic [DUTY_W-1:0] FALLBACK_RESET = 13'd1112;

  typedef struct packed {
    logic [MV_W-1:0]          setpoint_mv;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [DUTY_W-1:0]        wrap_threshold;
    logic [DUTY_W-1:0]        fallback_duty;
  } pid_cfg_t;

endpackage

FILE: sv/pid_dr_law.sv
`timescale 1ns / 1ps

module pid_dr_law (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [pid_dr_pkg::MV_W-1:0]         meas_mv,
  input  pid_dr_pkg::pid_cfg_t                cfg,
  output logic [pid_dr_pkg::DUTY_W-1:0]       duty
);

  localparam int ERR_W  = pid_dr_pkg::ERR_W;
  localparam int DIFF_W = ERR_W + 1;
  localparam int ISUM_W = pid_dr_pkg::ISUM_W;
  localparam int GAIN_W = pid_dr_pkg::GAIN_W;
  localparam int DUTY_W = pid_dr_pkg::DUTY_W;
  localparam int FRAC_W = pid_dr_pkg::FRAC_W;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int PI_W   = GAIN_W + ISUM_W;
  localparam int PD_W   = GAIN_W + DIFF_W;
  localparam int ACC_W  = PI_W + 2;
  localparam int DLT_W  = ACC_W - FRAC_W;
  localparam int NXT_W  = DLT_W + 1;

  logic signed [ISUM_W-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0]  last_error_r;
  logic [DUTY_W-1:0]        duty_now_r, duty_now_nxt;

  logic signed [ERR_W-1:0]  err;
  logic signed [ISUM_W:0]   sum_wide;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]  acc, acc_adj;
  logic signed [DLT_W-1:0]  delta;
  logic signed [NXT_W-1:0]  next_duty;
  logic signed [NXT_W-1:0]  thr_ext;

  // Form the error and the saturating integral
  always_comb begin
    err = $signed({1'b0, cfg.setpoint_mv}) - $signed({1'b0, meas_mv});
    sum_wide = ISUM_W'(0) + (ISUM_W + 1)'(error_sum_r) + (ISUM_W + 1)'(err);
    if (sum_wide[ISUM_W] != sum_wide[ISUM_W-1]) begin
      error_sum_nxt = sum_wide[ISUM_W] ? {1'b1, {(ISUM_W-1){1'b0}}}
                                       : {1'b0, {(ISUM_W-1){1'b1}}};
    end else begin
      error_sum_nxt = sum_wide[ISUM_W-1:0];
    end
    diff = DIFF_W'(err) - DIFF_W'(last_error_r);
  end

  // Three gain products, summed exactly in Q16.16
  always_comb begin
    prod_p = PP_W'(cfg.gain_p) * PP_W'(err);
    prod_i = PI_W'(cfg.gain_i) * PI_W'(error_sum_nxt);
    prod_d = PD_W'(cfg.gain_d) * PD_W'(diff);
    acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
  end

  // Truncate toward zero, apply to duty, then limit
  always_comb begin
    acc_adj   = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
    delta     = acc_adj[ACC_W-1:FRAC_W];
    next_duty = NXT_W'($signed({1'b0, duty_now_r})) + NXT_W'(delta);
    thr_ext   = $signed(NXT_W'(cfg.wrap_threshold));
    if (next_duty >= thr_ext) begin
      duty_now_nxt = cfg.fallback_duty;
    end else if (next_duty[NXT_W-1]) begin
      duty_now_nxt = '0;
    end else begin
      duty_now_nxt = next_duty[DUTY_W-1:0];
    end
  end

  // Advance the controller state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
      duty_now_r   <= pid_dr_pkg::DUTY_RESET;
    end else if (step) begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= err;
      duty_now_r   <= duty_now_nxt;
    end
  end

  assign duty = duty_now_r;

`ifndef SYNTHESIS
  // A new duty is the fallback, zero, or below the threshold in force
  a_duty_limited: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(step) |->
      (duty_now_r == $past(cfg.fallback_duty)) ||
      (duty_now_r == '0) ||
      (duty_now_r < $past(cfg.wrap_threshold)))
    else $error("duty escaped the limiter");

  // State holds between items
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(step) |->
      $stable(error_sum_r) && $stable(last_error_r) && $stable(duty_now_r))
    else $error("controller state moved without an item");
`endif

endmodule

FILE: sv/pid_duty_regulator_top.sv
`timescale 1ns / 1ps

// Incremental PID regulator producing a duty count from voltage samples.
// in_*  : one beat per measured sample, in_tdata[15:0] = measured_mv.
// out_* : one beat per sample, out_tdata[12:0] = duty, upper bits zero.
// cfg_* : register writes (index 0 setpoint, 1..3 gains P/I/D in Q16.16,
//         4 wrap threshold, 5 fallback duty); indexes 6 and 7 are ignored.
//         cfg_ready is always high; write only while no sample is in flight.
// Throughput: one sample per cycle while out_tready is high. An input
// register feeds the error, integral, three products and duty limiting,
// whose result lands in the duty state register that also drives
// out_tdata.
// Reset: integral and previous error clear, duty returns to 1500, gains
// and setpoint clear, threshold 7150, fallback 1112, both channels empty.
// Stall: while out_tready is low the result holds; one more sample is
// taken into the input register, then in_tready drops until the result
// beat is taken.
module pid_duty_regulator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [15:0]                           in_tdata,   // [15:0] measured_mv
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [15:0]                           out_tdata,  // [12:0] duty, [15:13] zero
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pid_dr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pid_dr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MV_W   = pid_dr_pkg::MV_W;
  localparam int DUTY_W = pid_dr_pkg::DUTY_W;

  pid_dr_pkg::pid_cfg_t cfg_r;
  logic                 in_valid_r;
  logic [MV_W-1:0]      meas_r;
  logic                 out_valid_r;
  logic                 advance;
  logic                 step;
  logic [DUTY_W-1:0]    duty;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_mv    <= '0;
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.wrap_threshold <= pid_dr_pkg::THRESH_RESET;
      cfg_r.fallback_duty  <= pid_dr_pkg::FALLBACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pid_dr_pkg::REG_SETPOINT:  cfg_r.setpoint_mv    <= cfg_data[MV_W-1:0];
        pid_dr_pkg::REG_GAIN_P:    cfg_r.gain_p         <= cfg_data;
        pid_dr_pkg::REG_GAIN_I:    cfg_r.gain_i         <= cfg_data;
        pid_dr_pkg::REG_GAIN_D:    cfg_r.gain_d         <= cfg_data;
        pid_dr_pkg::REG_THRESHOLD: cfg_r.wrap_threshold <= cfg_data[DUTY_W-1:0];
        pid_dr_pkg::REG_FALLBACK:  cfg_r.fallback_duty  <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the result slot frees when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      meas_r <= in_tdata[MV_W-1:0];
    end
  end

  // Result beat valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  pid_dr_law u_law (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .meas_mv (meas_r),
    .cfg     (cfg_r),
    .duty    (duty)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(16 - DUTY_W)'(0), duty};

`ifndef SYNTHESIS
  // Input stalls only when both stages are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

  // An accepted beat occupies the input register
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_valid_r)
    else $error("accepted beat lost at the input register");

  // A step always yields a result beat
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("step produced no result beat");
`endif

endmodule
